FILE: rtl/erl_pkg.sv
`default_nettype none
package erl_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W = 3;
  localparam int TYPE_W = 8;
  localparam int TIME_W = 32;
  localparam int POS_W  = 8;
  localparam int AMT_W  = 8;
  localparam int STAT_W = 3;
  localparam int FILL_W = 6;

  // Highest event type a restore accepts
  localparam logic [TYPE_W-1:0] RESTORE_TYPE_MAX = 8'd3;

  // Command kinds
  localparam logic [KIND_W-1:0] K_APPEND     = 3'd0;
  localparam logic [KIND_W-1:0] K_READ       = 3'd1;
  localparam logic [KIND_W-1:0] K_PURGE      = 3'd2;
  localparam logic [KIND_W-1:0] K_DUMP       = 3'd3;
  localparam logic [KIND_W-1:0] K_RST_START  = 3'd4;
  localparam logic [KIND_W-1:0] K_RST_EVENT  = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_POS      = 3'd2;
  localparam logic [STAT_W-1:0] ST_PURGE_MANY   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RESTORE_MANY = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_TYPE     = 3'd5;
  localparam logic [STAT_W-1:0] ST_UNEXPECTED   = 3'd6;

  typedef struct packed {
    logic load;     // capture the request word
    logic exec;     // carry out the captured command
    logic fetch;    // move read data into the result register
    logic advance;  // step the dump to the next entry
  } erl_cmd_t;

  typedef struct packed {
    logic need_read;  // command needs a table read before its result
    logic no_result;  // command produces no result (empty dump)
    logic more;       // dump has entries after the current one
  } erl_stat_t;

  // (base + off) mod CAPACITY, for base < CAPACITY and off <= CAPACITY
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
    if (s >= (CNT_W + 1)'(CAPACITY)) s = s - (CNT_W + 1)'(CAPACITY);
    return s[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/erl_if.sv
`default_nettype none
interface erl_req_if import erl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TYPE_W-1:0] event_type;
  logic [TIME_W-1:0] timestamp;
  logic [POS_W-1:0]  position;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, kind, event_type, timestamp, position, amount,
                  input ready);
  modport sink   (input valid, kind, event_type, timestamp, position, amount,
                  output ready);
endinterface

interface erl_rsp_if import erl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TYPE_W-1:0] out_type;
  logic [TIME_W-1:0] out_time;
  logic [FILL_W-1:0] fill;
  logic              last;

  modport source (output valid, status, out_type, out_time, fill, last,
                  input ready);
  modport sink   (input valid, status, out_type, out_time, fill, last,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/erl_ctrl.sv
`default_nettype none
module erl_ctrl import erl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      out_ready,
  input  wire erl_stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output erl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.no_result) state_next = S_IDLE;
        else if (stat.need_read)     state_next = S_READ;
        else                         state_next = S_OUT;
      end
      S_READ: begin
        cmd.fetch  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.more) begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("captured word not executed next cycle");

  a_fetch_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> out_valid)
    else $error("read data fetched but no result offered");

endmodule
`default_nettype wire

FILE: rtl/erl_dp.sv
`default_nettype none
module erl_dp import erl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire erl_cmd_t          cmd,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [TYPE_W-1:0] event_type,
  input  wire logic [TIME_W-1:0] timestamp,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [AMT_W-1:0]  amount,
  output erl_stat_t              stat,
  output logic [STAT_W-1:0]      status,
  output logic [TYPE_W-1:0]      out_type,
  output logic [TIME_W-1:0]      out_time,
  output logic [FILL_W-1:0]      fill,
  output logic                   last
);

  // captured request
  logic [KIND_W-1:0] kind_q;
  logic [TYPE_W-1:0] type_q;
  logic [TIME_W-1:0] time_q;
  logic [POS_W-1:0]  pos_q;
  logic [AMT_W-1:0]  amt_q;

  // log state
  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  held, held_next;
  logic              restoring, restoring_next;
  logic [CNT_W-1:0]  restore_pos, restore_pos_next;
  logic [CNT_W-1:0]  restore_total, restore_total_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  rpos_inc;

  // table
  logic [TYPE_W+TIME_W-1:0] mem [CAPACITY];
  logic [TYPE_W+TIME_W-1:0] rd_data;
  logic                     wr_en, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic [STAT_W-1:0]        res_status;

  logic pos_ok;

  assign idx_inc  = idx + CNT_W'(1);
  assign rpos_inc = restore_pos + CNT_W'(1);
  assign pos_ok   = pos_q < POS_W'(CAPACITY);

  assign stat.need_read = ((kind_q == K_READ) && pos_ok) ||
                          ((kind_q == K_DUMP) && (held != '0));
  assign stat.no_result = (kind_q == K_DUMP) && (held == '0);
  assign stat.more      = (kind_q == K_DUMP) && (idx_inc != held);

  always_comb begin
    head_next          = head;
    held_next          = held;
    restoring_next     = restoring;
    restore_pos_next   = restore_pos;
    restore_total_next = restore_total;
    wr_en              = 1'b0;
    wr_addr            = ring_add(head, held);
    rd_en              = 1'b0;
    rd_addr            = head;
    res_status         = ST_OK;
    if (cmd.exec) begin
      unique case (kind_q)
        K_APPEND: begin
          if (held >= CNT_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            held_next = held + CNT_W'(1);
          end
        end
        K_READ: begin
          if (!pos_ok) begin
            res_status = ST_BAD_POS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ring_add(head, pos_q[CNT_W-1:0]);
          end
        end
        K_PURGE: begin
          if (amt_q > AMT_W'(held)) begin
            res_status = ST_PURGE_MANY;
          end else begin
            head_next = ring_add(head, amt_q[CNT_W-1:0]);
            held_next = held - amt_q[CNT_W-1:0];
          end
        end
        K_DUMP: begin
          rd_en = held != '0;
        end
        K_RST_START: begin
          if (amt_q > AMT_W'(CAPACITY)) begin
            res_status = ST_RESTORE_MANY;
          end else begin
            held_next          = amt_q[CNT_W-1:0];
            head_next          = '0;
            restore_pos_next   = '0;
            restore_total_next = amt_q[CNT_W-1:0];
            restoring_next     = amt_q != '0;
          end
        end
        K_RST_EVENT: begin
          priority if (!restoring) begin
            res_status = ST_UNEXPECTED;
          end else if (type_q > RESTORE_TYPE_MAX) begin
            res_status       = ST_BAD_TYPE;
            held_next        = '0;
            head_next        = '0;
            restoring_next   = 1'b0;
            restore_pos_next = '0;
          end else begin
            wr_en            = 1'b1;
            wr_addr          = restore_pos[ADDR_W-1:0];
            restore_pos_next = rpos_inc;
            if (rpos_inc >= restore_total) restoring_next = 1'b0;
          end
        end
        default: res_status = ST_OK;
      endcase
    end
    if (cmd.advance) begin
      rd_en   = 1'b1;
      rd_addr = ring_add(head, idx_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {type_q, time_q};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      type_q <= event_type;
      time_q <= timestamp;
      pos_q  <= position;
      amt_q  <= amount;
    end
    if (cmd.exec && !stat.need_read && !stat.no_result) begin
      status   <= res_status;
      out_type <= '0;
      out_time <= '0;
      fill     <= FILL_W'(held_next);
      last     <= 1'b1;
    end else if (cmd.fetch) begin
      status   <= ST_OK;
      out_type <= rd_data[TYPE_W+TIME_W-1:TIME_W];
      out_time <= rd_data[TIME_W-1:0];
      fill     <= FILL_W'(held);
      last     <= !stat.more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      held          <= '0;
      restoring     <= 1'b0;
      restore_pos   <= '0;
      restore_total <= '0;
      idx           <= '0;
    end else begin
      head          <= head_next;
      held          <= held_next;
      restoring     <= restoring_next;
      restore_pos   <= restore_pos_next;
      restore_total <= restore_total_next;
      if (cmd.exec)         idx <= '0;
      else if (cmd.advance) idx <= idx_inc;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(CAPACITY))
    else $error("log holds more than its capacity");

  a_restore_range: assert property (@(posedge clk) disable iff (rst)
    restoring |-> (restore_pos < restore_total))
    else $error("pending restore past its count");

  a_fetch_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> $past(rd_en))
    else $error("result fetched without a table read");

endmodule
`default_nettype wire

FILE: rtl/event_ring_log.sv
`default_nettype none
// Circular log of (event type, timestamp) words, up to 32 entries, oldest
// at head. A request word carries a kind: append, read by position from
// the oldest entry, purge from the oldest end, dump of every held entry,
// restore start (count) and restore event (one entry). Each request gives
// one result word with last set, except dump, which gives one word per held
// entry, oldest first, last set on the final one, and nothing on an empty
// log. The block takes one request at a time: a request that needs no
// table read passes capture, execute and present, where its result is
// offered until taken, then goes back to idle; a read also passes the
// registered table port; a dump passes capture and execute, then every
// entry goes through the single read port and the result register; an
// empty dump goes back to idle after execute.
// Backpressure on the result side simply holds the word.
// Table contents have no reset; reading a slot never written returns
// undefined data. Unused kinds give one OK result and change nothing.
module event_ring_log import erl_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  erl_req_if.sink   req,
  erl_rsp_if.source rsp
);

  erl_cmd_t  cmd;
  erl_stat_t stat;

  // sequencing: capture, execute, table read, result hand-off
  erl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  // ring pointers, restore tracking, event table and result register
  erl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (req.kind),
    .event_type (req.event_type),
    .timestamp  (req.timestamp),
    .position   (req.position),
    .amount     (req.amount),
    .stat       (stat),
    .status     (rsp.status),
    .out_type   (rsp.out_type),
    .out_time   (rsp.out_time),
    .fill       (rsp.fill),
    .last       (rsp.last)
  );

endmodule
`default_nettype wire
